// ----- design/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared item types, operation codes and cell control for the list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned ENTRY_W       = 32;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned COUNT_OUT_W   = 9;
  localparam int unsigned DEPTH_DEFAULT = 256;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic signed [ENTRY_W-1:0] BAD_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]                op;
    logic [POS_W-1:0]          position;
    logic signed [ENTRY_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] value_out;
    logic                      ok;
    logic [COUNT_OUT_W-1:0]    count_now;
  } out_item_t;

  typedef struct packed {
    logic app;
    logic rem;
    logic snap;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/ils_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list entry and one readout tap; loads from its upper neighbor.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic                         clk_i,
  input  ils_pkg::cell_ctrl_t          ctrl_i,
  input  logic [CW-1:0]                count_i,
  input  logic [ils_pkg::POS_W-1:0]    pos_i,
  input  logic [ils_pkg::ENTRY_W-1:0]  value_i,
  input  logic [ils_pkg::ENTRY_W-1:0]  nxt_entry_i,
  input  logic [ils_pkg::ENTRY_W-1:0]  nxt_tap_i,
  output logic [ils_pkg::ENTRY_W-1:0]  entry_o,
  output logic [ils_pkg::ENTRY_W-1:0]  tap_o
);
  import ils_pkg::*;

  localparam int unsigned CMPW = CW + POS_W;

  logic [ENTRY_W-1:0] entry_q;
  logic [ENTRY_W-1:0] tap_q;
  logic               hit_app;
  logic               hit_rem;

  assign hit_app = ctrl_i.app & (count_i == CW'(IDX));
  assign hit_rem = ctrl_i.rem & (CMPW'(IDX) >= CMPW'(pos_i));

  always_ff @(posedge clk_i) begin
    if (hit_app) begin
      entry_q <= value_i;
    end else if (hit_rem) begin
      entry_q <= nxt_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap) begin
      tap_q <= entry_q;
    end else if (ctrl_i.shift) begin
      tap_q <= nxt_tap_i;
    end
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;

endmodule

// ----- design/indexed_list_store_core.sv -----
// ----------------------------------------------------------------------------
// Indexed list store core
// Ordered list of signed words in a row of cells, with append, get, remove
// and clear, and the running count reported with every result.
// ----------------------------------------------------------------------------
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   in       | in_valid_i / in_stall_o  | in_item_i  (op, position, value_in)
//   out      | out_valid_o/ out_stall_i | out_item_o (value_out, ok, count_now)
//
// Append, clear and any out-of-range get or remove answer in the next cycle.
// A valid get or remove snapshots all entries into the tap chain, shifts it
// toward cell 0 once per cycle, position times, then registers the result
// from the cell 0 tap once the output side is free.
// Reset clears the count and control only; entries are not cleared.
// A held result stalls the input side until it is taken.
// ----------------------------------------------------------------------------
module indexed_list_store_core #(
  parameter int unsigned DEPTH = ils_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ils_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ils_pkg::out_item_t out_item_o
);
  import ils_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = CW + POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                   state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [POS_W-1:0]       walk_q, walk_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  cell_ctrl_t             ctrl;
  logic                   accept;
  logic                   out_free;
  logic                   full;
  logic                   bad;
  logic [CW+COUNT_OUT_W-1:0] cnt_wide;
  logic [ENTRY_W-1:0]     entry_w [DEPTH];
  logic [ENTRY_W-1:0]     tap_w   [DEPTH];

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q == S_WALK) | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CW'(DEPTH));
  assign bad        = (CMPW'(in_item_i.position) >= CMPW'(count_q));
  assign cnt_wide   = {{COUNT_OUT_W{1'b0}}, count_d};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    ctrl        = '0;
    if (state_q == S_WALK) begin
      if (walk_q != '0) begin
        ctrl.shift = 1'b1;
        walk_d     = walk_q - 1'b1;
      end else if (out_free) begin
        out_valid_d     = 1'b1;
        out_d.value_out = tap_w[0];
        out_d.ok        = 1'b1;
        out_d.count_now = cnt_wide[COUNT_OUT_W-1:0];
        state_d         = S_IDLE;
      end
    end else if (accept) begin
      unique case (in_item_i.op)
        OP_APPEND: begin
          if (!full) begin
            ctrl.app = 1'b1;
            count_d  = count_q + 1'b1;
          end
          out_valid_d     = 1'b1;
          out_d.value_out = '0;
          out_d.ok        = ~full;
          out_d.count_now = cnt_wide[COUNT_OUT_W-1:0];
        end
        OP_GET, OP_REMOVE: begin
          if (bad) begin
            out_valid_d     = 1'b1;
            out_d.value_out = BAD_VALUE;
            out_d.ok        = 1'b0;
            out_d.count_now = cnt_wide[COUNT_OUT_W-1:0];
          end else begin
            ctrl.snap = 1'b1;
            if (in_item_i.op == OP_REMOVE) begin
              ctrl.rem = 1'b1;
              count_d  = count_q - 1'b1;
            end
            walk_d  = in_item_i.position;
            state_d = S_WALK;
          end
        end
        OP_CLEAR: begin
          count_d         = '0;
          out_valid_d     = 1'b1;
          out_d.value_out = '0;
          out_d.ok        = 1'b1;
          out_d.count_now = cnt_wide[COUNT_OUT_W-1:0];
        end
        default: begin
          out_valid_d = out_valid_q & out_stall_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ENTRY_W-1:0] nxt_entry;
    logic [ENTRY_W-1:0] nxt_tap;
    if (k == DEPTH - 1) begin : g_last
      assign nxt_entry = '0;
      assign nxt_tap   = '0;
    end else begin : g_mid
      assign nxt_entry = entry_w[k+1];
      assign nxt_tap   = tap_w[k+1];
    end
    ils_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .pos_i       (in_item_i.position),
      .value_i     (in_item_i.value_in),
      .nxt_entry_i (nxt_entry),
      .nxt_tap_i   (nxt_tap),
      .entry_o     (entry_w[k]),
      .tap_o       (tap_w[k])
    );
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count exceeds depth");

  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_item_i.op == OP_APPEND) && full |=> count_q == $past(count_q))
    else $error("append to full list changed the count");

  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && (walk_q != '0)
      |=> (state_q == S_WALK) && (walk_q == $past(walk_q) - 1'b1))
    else $error("tap walk did not advance");

  a_walk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && (walk_q == '0) && out_free
      |=> out_valid_q && out_q.ok && (state_q == S_IDLE))
    else $error("tap walk ended without a result");
`endif

endmodule
